// ===== hdl/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier modules.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int CntW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POLARITY = 2'd3;

  localparam logic [CntW-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CntW-1:0] DOUBLE_RST = 16'd400;
  localparam logic [CntW-1:0] LONG_RST = 16'd2000;
  localparam logic POLARITY_RST = 1'b1;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;
  localparam logic [1:0] MODE_PLAY = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG = 2'd3;

  typedef struct packed {
    logic       raw_level;
    logic [1:0] mode;
    logic       cancel;
  } in_word_t;

  typedef struct packed {
    logic [1:0] gesture_event;
    logic       click_waiting;
    logic       debounced_pressed;
  } out_word_t;

  typedef struct packed {
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] double_click_ticks;
    logic [CntW-1:0] long_press_ticks;
    logic            pressed_polarity;
  } cfg_t;

  typedef struct packed {
    logic            started;
    logic            last_raw;
    logic            stable_pressed;
    logic            ignore_press;
    logic            ignore_long;
    logic            long_done;
    logic            click_pending;
    logic [CntW-1:0] since_change;
    logic [CntW-1:0] press_elapsed;
    logic [CntW-1:0] since_release;
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/button_click_classifier_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Debounces a sampled button level and reports single, double and long presses.
// ----------------------------------------------------------------------------
// Each input word is one time tick and yields exactly one result word,
// registered in the cycle after it is accepted. The block takes a word in
// every cycle while the result register is empty or is being read in the
// same cycle: the tick logic is combinational between the held classifier
// state and the result register. Configuration writes take effect on the
// next accepted word.
module button_click_classifier_top (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire bcc_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output bcc_pkg::out_word_t      out_data,
  input  wire                     cfg_we,
  input  wire [bcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire [bcc_pkg::CfgDataW-1:0] cfg_wdata
);

  bcc_pkg::cfg_t      cfg_r;
  bcc_pkg::state_t    state_r;
  bcc_pkg::state_t    state_nxt;
  bcc_pkg::out_word_t res;
  logic               accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= bcc_pkg::DEBOUNCE_RST;
      cfg_r.double_click_ticks <= bcc_pkg::DOUBLE_RST;
      cfg_r.long_press_ticks   <= bcc_pkg::LONG_RST;
      cfg_r.pressed_polarity   <= bcc_pkg::POLARITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::CFG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_wdata;
        bcc_pkg::CFG_DOUBLE:   cfg_r.double_click_ticks <= cfg_wdata;
        bcc_pkg::CFG_LONG:     cfg_r.long_press_ticks   <= cfg_wdata;
        bcc_pkg::CFG_POLARITY: cfg_r.pressed_polarity   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  bcc_step u_step (
    .in_word (in_data),
    .cfg     (cfg_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .res     (res)
  );

  bcc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_valid),
    .load_data (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/bcc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_step
// Next-state and result logic for one tick of the gesture classifier.
// ----------------------------------------------------------------------------
module bcc_step (
  input  wire bcc_pkg::in_word_t  in_word,
  input  wire bcc_pkg::cfg_t      cfg,
  input  wire bcc_pkg::state_t    cur,
  output bcc_pkg::state_t         nxt,
  output bcc_pkg::out_word_t      res
);

  logic                      raw_p;
  logic                      fired;
  logic                      held;
  logic [1:0]                ev;
  logic [bcc_pkg::CntW-1:0]  sc_inc;
  logic [bcc_pkg::CntW-1:0]  pe_inc;
  logic [bcc_pkg::CntW-1:0]  sr_inc;

  assign raw_p  = (in_word.raw_level == cfg.pressed_polarity);
  assign sc_inc = (&cur.since_change) ? cur.since_change : cur.since_change + 1'b1;
  assign pe_inc = (&cur.press_elapsed) ? cur.press_elapsed : cur.press_elapsed + 1'b1;
  assign sr_inc = (&cur.since_release) ? cur.since_release : cur.since_release + 1'b1;

  always_comb begin
    nxt   = cur;
    ev    = bcc_pkg::EV_NONE;
    fired = 1'b0;
    held  = 1'b0;
    if (!cur.started) begin
      nxt.started        = 1'b1;
      nxt.last_raw       = in_word.raw_level;
      nxt.stable_pressed = raw_p;
      nxt.since_change   = '0;
      nxt.press_elapsed  = '0;
      nxt.since_release  = '0;
      nxt.ignore_press   = raw_p;
      nxt.ignore_long    = raw_p;
    end else begin
      nxt.since_change  = sc_inc;
      nxt.press_elapsed = pe_inc;
      nxt.since_release = sr_inc;
    end

    if (in_word.raw_level != nxt.last_raw) begin
      nxt.last_raw     = in_word.raw_level;
      nxt.since_change = '0;
    end

    if (raw_p && nxt.stable_pressed && !nxt.long_done && !nxt.ignore_long &&
        nxt.press_elapsed >= cfg.long_press_ticks) begin
      nxt.long_done     = 1'b1;
      nxt.click_pending = 1'b0;
      nxt.ignore_press  = 1'b1;
      ev                = bcc_pkg::EV_LONG;
      fired             = 1'b1;
    end

    if (!fired && nxt.since_change >= cfg.debounce_ticks &&
        raw_p != nxt.stable_pressed) begin
      nxt.stable_pressed = raw_p;
      if (raw_p) begin
        nxt.press_elapsed = '0;
        nxt.long_done     = 1'b0;
        nxt.ignore_press  = (in_word.mode >= bcc_pkg::MODE_PLAY);
      end else if (nxt.ignore_press) begin
        nxt.ignore_press = 1'b0;
        nxt.ignore_long  = 1'b0;
        nxt.long_done    = 1'b0;
      end else if (nxt.long_done) begin
        nxt.long_done   = 1'b0;
        nxt.ignore_long = 1'b0;
      end else if (in_word.mode == bcc_pkg::MODE_RECORD) begin
        nxt.click_pending = 1'b0;
        ev                = bcc_pkg::EV_SINGLE;
      end else if (in_word.mode == bcc_pkg::MODE_NORMAL) begin
        if (nxt.click_pending) begin
          nxt.click_pending = 1'b0;
          ev                = bcc_pkg::EV_DOUBLE;
        end else begin
          nxt.click_pending = 1'b1;
          nxt.since_release = '0;
        end
      end
    end

    held = (nxt.last_raw == cfg.pressed_polarity) || nxt.stable_pressed;
    if (nxt.click_pending && !held && nxt.since_release >= cfg.double_click_ticks) begin
      nxt.click_pending = 1'b0;
      ev                = bcc_pkg::EV_SINGLE;
    end

    if (in_word.cancel) begin
      nxt.click_pending = 1'b0;
      if (held) begin
        nxt.ignore_press = 1'b1;
      end
    end

    res.gesture_event     = ev;
    res.click_waiting     = nxt.click_pending;
    res.debounced_pressed = nxt.stable_pressed;
  end

endmodule
`default_nettype wire

// ===== hdl/bcc_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_out_reg
// Result register that holds one word until the consumer takes it.
// ----------------------------------------------------------------------------
module bcc_out_reg (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     load,
  input  wire bcc_pkg::out_word_t load_data,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire                     out_ready,
  output bcc_pkg::out_word_t      out_data
);

  logic               valid_r;
  bcc_pkg::out_word_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== tb/button_click_classifier_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_checker
// Watches the input, result and configuration ports of the button click
// classifier, predicts one result word per accepted tick word from its own
// copy of the classifier state and compares it, field by field, with the
// word that leaves the block.
// ----------------------------------------------------------------------------
module button_click_classifier_checker (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  input  wire                         in_ready,
  input  bcc_pkg::in_word_t           in_data,
  input  wire                         out_valid,
  input  wire                         out_ready,
  input  bcc_pkg::out_word_t          out_data,
  input  wire                         cfg_we,
  input  wire [bcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire [bcc_pkg::CfgDataW-1:0] cfg_wdata,
  output int                          mismatch_count,
  output int                          results_waiting
);

  bcc_pkg::cfg_t      shadow;
  bcc_pkg::state_t    trk;
  bcc_pkg::out_word_t gesture_q[$];

  function automatic logic [bcc_pkg::CntW-1:0] bump(input logic [bcc_pkg::CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic classify_tick(input bcc_pkg::in_word_t w, output bcc_pkg::out_word_t r);
    logic       pressed_now;
    logic       held;
    logic       fired;
    logic [1:0] ev;
    pressed_now = (w.raw_level == shadow.pressed_polarity);
    ev = bcc_pkg::EV_NONE;
    fired = 1'b0;
    if (!trk.started) begin
      trk.started = 1'b1;
      trk.last_raw = w.raw_level;
      trk.stable_pressed = pressed_now;
      trk.since_change = '0;
      trk.press_elapsed = '0;
      trk.since_release = '0;
      trk.ignore_press = pressed_now;
      trk.ignore_long = pressed_now;
    end else begin
      trk.since_change = bump(trk.since_change);
      trk.press_elapsed = bump(trk.press_elapsed);
      trk.since_release = bump(trk.since_release);
    end
    if (w.raw_level != trk.last_raw) begin
      trk.last_raw = w.raw_level;
      trk.since_change = '0;
    end
    if (pressed_now && trk.stable_pressed && !trk.long_done && !trk.ignore_long &&
        trk.press_elapsed >= shadow.long_press_ticks) begin
      trk.long_done = 1'b1;
      trk.click_pending = 1'b0;
      trk.ignore_press = 1'b1;
      ev = bcc_pkg::EV_LONG;
      fired = 1'b1;
    end
    if (!fired && trk.since_change >= shadow.debounce_ticks &&
        pressed_now != trk.stable_pressed) begin
      trk.stable_pressed = pressed_now;
      if (trk.stable_pressed) begin
        trk.press_elapsed = '0;
        trk.long_done = 1'b0;
        trk.ignore_press = (w.mode >= bcc_pkg::MODE_PLAY);
      end else if (trk.ignore_press) begin
        trk.ignore_press = 1'b0;
        trk.ignore_long = 1'b0;
        trk.long_done = 1'b0;
      end else if (trk.long_done) begin
        trk.long_done = 1'b0;
        trk.ignore_long = 1'b0;
      end else if (w.mode == bcc_pkg::MODE_RECORD) begin
        trk.click_pending = 1'b0;
        ev = bcc_pkg::EV_SINGLE;
      end else if (w.mode == bcc_pkg::MODE_NORMAL) begin
        if (trk.click_pending) begin
          trk.click_pending = 1'b0;
          ev = bcc_pkg::EV_DOUBLE;
        end else begin
          trk.click_pending = 1'b1;
          trk.since_release = '0;
        end
      end
    end
    if (trk.click_pending) begin
      held = (trk.last_raw == shadow.pressed_polarity) || trk.stable_pressed;
      if (!held && trk.since_release >= shadow.double_click_ticks) begin
        trk.click_pending = 1'b0;
        ev = bcc_pkg::EV_SINGLE;
      end
    end
    if (w.cancel) begin
      trk.click_pending = 1'b0;
      if ((trk.last_raw == shadow.pressed_polarity) || trk.stable_pressed) begin
        trk.ignore_press = 1'b1;
      end
    end
    r.gesture_event = ev;
    r.click_waiting = trk.click_pending;
    r.debounced_pressed = trk.stable_pressed;
  endtask

  always @(posedge clk) begin : watch
    bcc_pkg::out_word_t want;
    if (!rst_n) begin
      shadow.debounce_ticks = bcc_pkg::DEBOUNCE_RST;
      shadow.double_click_ticks = bcc_pkg::DOUBLE_RST;
      shadow.long_press_ticks = bcc_pkg::LONG_RST;
      shadow.pressed_polarity = bcc_pkg::POLARITY_RST;
      trk = '0;
      gesture_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bcc_pkg::CFG_DEBOUNCE: shadow.debounce_ticks = cfg_wdata;
          bcc_pkg::CFG_DOUBLE:   shadow.double_click_ticks = cfg_wdata;
          bcc_pkg::CFG_LONG:     shadow.long_press_ticks = cfg_wdata;
          bcc_pkg::CFG_POLARITY: shadow.pressed_polarity = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (gesture_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result word with nothing expected: event %0d waiting %0b pressed %0b",
                     $realtime, out_data.gesture_event, out_data.click_waiting,
                     out_data.debounced_pressed);
          end
          mismatch_count++;
        end else begin
          want = gesture_q.pop_front();
          if (out_data.gesture_event !== want.gesture_event ||
              out_data.click_waiting !== want.click_waiting ||
              out_data.debounced_pressed !== want.debounced_pressed) begin
            if (mismatch_count < 10) begin
              $display("%0t: expected event %0d waiting %0b pressed %0b, got %0d %0b %0b",
                       $realtime, want.gesture_event, want.click_waiting,
                       want.debounced_pressed, out_data.gesture_event,
                       out_data.click_waiting, out_data.debounced_pressed);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        classify_tick(in_data, want);
        gesture_q.push_back(want);
      end
    end
    results_waiting = gesture_q.size();
  end

endmodule

// ===== tb/tb_button_click_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_classifier_top
// Drives tick words into the button click classifier in random bursts while
// the result side stalls on its own pattern. A directed opening covers the
// first tick after reset, zero thresholds, both polarities, every mode and
// cancel; random gesture phases follow under several configurations. A
// separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_button_click_classifier_top;

  localparam logic [1:0] MODE_PLAY_ALT = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  bcc_pkg::in_word_t            in_data;
  logic                         out_valid;
  logic                         out_ready;
  bcc_pkg::out_word_t           out_data;
  logic                         cfg_we;
  logic [bcc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [bcc_pkg::CfgDataW-1:0] cfg_wdata;

  int   mismatch_count;
  int   results_waiting;
  int   in_taken = 0;
  int   sent = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  bit   hold_off_req = 1'b0;
  int   cur_deb;
  int   cur_dbl;
  int   cur_long;
  logic cur_pol;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_click_classifier_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  button_click_classifier_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting)
  );

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_taken <= in_taken + 1;
    end
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_button_click_classifier_top: errors");
      $finish;
    end
  end

  initial begin : rx_pattern
    int pattern;
    int span;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      pattern = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        case (pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % 3 != 0);
          default: out_ready <= (k % 4 == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic send_tick(input logic raw, input logic [1:0] mode, input logic cancel);
    bcc_pkg::in_word_t w;
    int                gap;
    w.raw_level = raw;
    w.mode = mode;
    w.cancel = cancel;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data <= w;
    sent++;
    while (in_taken != sent) @(negedge clk);
  endtask

  task automatic hold_level(input logic raw, input logic [1:0] mode, input int n,
                            input int cancel_at);
    for (int i = 0; i < n; i++) begin
      send_tick(raw, mode, i == cancel_at);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_waiting != 0 || in_taken != sent);
    repeat (2) @(negedge clk);
  endtask

  task automatic apply_config(input int deb, input int dbl, input int lng, input logic pol);
    logic [bcc_pkg::CfgDataW-1:0] pol_word;
    pol_word = bcc_pkg::CfgDataW'($urandom);
    pol_word[0] = pol;
    cur_deb = deb;
    cur_dbl = dbl;
    cur_long = lng;
    cur_pol = pol;
    cfg_we <= 1'b1;
    cfg_index <= bcc_pkg::CFG_DEBOUNCE;
    cfg_wdata <= bcc_pkg::CfgDataW'(deb);
    @(negedge clk);
    cfg_index <= bcc_pkg::CFG_DOUBLE;
    cfg_wdata <= bcc_pkg::CfgDataW'(dbl);
    @(negedge clk);
    cfg_index <= bcc_pkg::CFG_LONG;
    cfg_wdata <= bcc_pkg::CfgDataW'(lng);
    @(negedge clk);
    cfg_index <= bcc_pkg::CFG_POLARITY;
    cfg_wdata <= pol_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return bcc_pkg::MODE_NORMAL;
      4, 5, 6:    return bcc_pkg::MODE_RECORD;
      7, 8:       return bcc_pkg::MODE_PLAY;
      default:    return MODE_PLAY_ALT;
    endcase
  endfunction

  // One press and release with random lengths around the current thresholds,
  // sometimes with a bounce in front or a cancel inside, sometimes plain noise.
  task automatic play_gesture();
    int         deb_c;
    int         dbl_c;
    int         long_c;
    int         press_len;
    int         rel_len;
    int         cancel_at;
    logic [1:0] m;
    logic       dn;
    deb_c = (cur_deb > 6) ? 6 : cur_deb;
    dbl_c = (cur_dbl > 16) ? 16 : cur_dbl;
    long_c = (cur_long > 24) ? 24 : cur_long;
    dn = cur_pol;
    m = pick_mode();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  $urandom_range(0, 7) == 0);
      end
      return;
    end
    if ($urandom_range(0, 4) == 0) begin
      send_tick(dn, m, 1'b0);
      send_tick(!dn, m, 1'b0);
    end
    case ($urandom_range(0, 2))
      0: press_len = $urandom_range(1, deb_c + 2);
      1: press_len = $urandom_range(deb_c + 1, deb_c + long_c + 2);
      default: press_len = deb_c + long_c + $urandom_range(1, 4);
    endcase
    cancel_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, press_len - 1) : -1;
    hold_level(dn, m, press_len, cancel_at);
    if ($urandom_range(0, 3) == 0) begin
      m = pick_mode();
    end
    case ($urandom_range(0, 2))
      0: rel_len = $urandom_range(deb_c + 1, deb_c + dbl_c + 1);
      1: rel_len = deb_c + dbl_c + $urandom_range(1, 6);
      default: rel_len = $urandom_range(1, deb_c + 1);
    endcase
    cancel_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rel_len - 1) : -1;
    hold_level(!dn, m, rel_len, cancel_at);
  endtask

  initial begin : stimulus
    int phase_start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = bcc_pkg::CFG_DEBOUNCE;
    cfg_wdata = '0;
    cur_deb = bcc_pkg::DEBOUNCE_RST;
    cur_dbl = bcc_pkg::DOUBLE_RST;
    cur_long = bcc_pkg::LONG_RST;
    cur_pol = bcc_pkg::POLARITY_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Button already pressed on the first tick after reset.
    hold_level(1'b1, bcc_pkg::MODE_NORMAL, 3, -1);
    hold_level(1'b0, bcc_pkg::MODE_PLAY, 2, 1);
    drain();

    // Zero thresholds.
    apply_config(0, 0, 0, 1'b1);
    hold_level(1'b1, bcc_pkg::MODE_RECORD, 2, -1);
    hold_level(1'b0, bcc_pkg::MODE_RECORD, 1, -1);
    hold_level(1'b1, bcc_pkg::MODE_NORMAL, 1, -1);
    hold_level(1'b0, bcc_pkg::MODE_NORMAL, 1, -1);
    drain();

    // Active-low button: recording click, double click, mode three, cancel.
    apply_config(1, 3, 4, 1'b0);
    hold_level(1'b0, bcc_pkg::MODE_NORMAL, 2, -1);
    hold_level(1'b1, bcc_pkg::MODE_RECORD, 2, -1);
    hold_level(1'b0, bcc_pkg::MODE_NORMAL, 2, -1);
    hold_level(1'b1, bcc_pkg::MODE_NORMAL, 2, -1);
    hold_level(1'b0, bcc_pkg::MODE_NORMAL, 2, -1);
    hold_level(1'b1, bcc_pkg::MODE_NORMAL, 2, -1);
    hold_level(1'b0, MODE_PLAY_ALT, 2, -1);
    hold_level(1'b1, bcc_pkg::MODE_NORMAL, 2, -1);
    hold_level(1'b0, bcc_pkg::MODE_NORMAL, 2, 1);
    hold_level(1'b1, bcc_pkg::MODE_NORMAL, 2, -1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        3: apply_config($urandom_range(0, 3), $urandom_range(0, 12), 16'hFFFF,
                        1'($urandom_range(0, 1)));
        5: apply_config($urandom_range(0, 3), 16'hFFFF, $urandom_range(0, 20),
                        1'($urandom_range(0, 1)));
        default: apply_config($urandom_range(0, 4), $urandom_range(0, 12),
                              $urandom_range(0, 20), 1'($urandom_range(0, 1)));
      endcase
      if (ph == 1) begin
        hold_off_req = 1'b1;
      end
      phase_start = sent;
      while (sent - phase_start < 58) play_gesture();
      drain();
    end

    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_button_click_classifier_top: clean");
    end else begin
      $display("tb_button_click_classifier_top: errors");
    end
    $finish;
  end

endmodule
